// ----- hdl/sisp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sector image parser package
// Shared types, codes and the bytewise CRC-32 step.
// ----------------------------------------------------------------------------
package sisp_pkg;

  localparam int TagLimitDefault = 256;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  error_code;
    logic [7:0]  payload_byte;
    logic [7:0]  phys_cylinder;
    logic [7:0]  phys_head;
    logic [7:0]  id_cylinder;
    logic [7:0]  id_head;
    logic [7:0]  id_sector;
    logic [15:0] sector_length;
    logic [7:0]  encoding_code;
    logic [31:0] bit_rate;
    logic [4:0]  sector_flags;
  } out_word_t;

  localparam logic [2:0] KindHeader  = 3'd0;
  localparam logic [2:0] KindData    = 3'd1;
  localparam logic [2:0] KindTag     = 3'd2;
  localparam logic [2:0] KindComment = 3'd3;
  localparam logic [2:0] KindDone    = 3'd4;
  localparam logic [2:0] KindError   = 3'd5;

  localparam logic [3:0] ErrMagic    = 4'd0;
  localparam logic [3:0] ErrVersion  = 4'd1;
  localparam logic [3:0] ErrOffset   = 4'd2;
  localparam logic [3:0] ErrMarker   = 4'd3;
  localparam logic [3:0] ErrShort    = 4'd4;
  localparam logic [3:0] ErrOrphanAlt = 4'd5;
  localparam logic [3:0] ErrOrphanTag = 4'd6;
  localparam logic [3:0] ErrChunkCrc = 4'd7;
  localparam logic [3:0] ErrFileCrc  = 4'd8;

  localparam logic [15:0] IdSector  = 16'h5343;
  localparam logic [15:0] IdEnd     = 16'h454e;
  localparam logic [15:0] IdComment = 16'h434d;
  localparam logic [15:0] IdTag     = 16'h5447;
  localparam logic [7:0]  RecMarker = 8'h53;

  typedef enum logic [3:0] {
    PH_HDR, PH_SKIP, PH_REC, PH_RDATA, PH_DONEP, PH_DONE, PH_ERR, PH_CKH,
    PH_SCH, PH_SDATA, PH_TAG, PH_CMT, PH_CSKIP, PH_CCRC, PH_FCRC
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ 32'h04c11db7) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sisp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sector image parser result queue
// Small FIFO of result words between the parser core and the output port.
// ----------------------------------------------------------------------------
module sisp_queue #(
  parameter int DEPTH = sisp_pkg::QueueDepth
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  sisp_pkg::out_word_t  push_word,
  output logic                 almost_full,
  output logic                 valid,
  input  wire                  stall,
  output sisp_pkg::out_word_t  word
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sisp_pkg::out_word_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          pop;

  assign pop = (count != '0) && !stall;
  assign valid = (count != '0);
  assign word = mem[rd_ptr];
  // Leaves room for the word still in flight in the core.
  assign almost_full = (count >= (AW+1)'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sisp_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sector image parser core
// Takes one file byte per cycle while take is high, tracks the parse phase and builds results.
// ----------------------------------------------------------------------------
module sisp_core #(
  parameter int TAG_LIMIT = sisp_pkg::TagLimitDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [31:0]         expected_magic,
  input  wire                 take,
  input  sisp_pkg::in_word_t  in_word,
  output logic                res_valid,
  output sisp_pkg::out_word_t res_word
);
  sisp_pkg::phase_t phase, phase_next;
  logic [1:0]  version, version_next;
  logic [31:0] records_left, records_left_next;
  logic [31:0] skip_left, skip_left_next;
  logic [4:0]  field_index, field_index_next;
  logic [7:0]  hb [16];
  logic [7:0]  hb_next [16];
  logic [15:0] chunk_rem, chunk_rem_next;
  logic [15:0] data_rem, data_rem_next;
  logic [31:0] chunk_crc, chunk_crc_next;
  logic [31:0] file_crc, file_crc_next;
  logic [31:0] check_word, check_word_next;
  logic        prior, prior_next;
  logic        end_chunk, end_chunk_next;
  logic        rv;
  sisp_pkg::out_word_t rw;

  always_ff @(posedge clk) begin
    hb <= hb_next;
    res_word <= rw;
    if (rst) begin
      phase <= sisp_pkg::PH_HDR;
      version <= '0;
      records_left <= '0;
      skip_left <= '0;
      field_index <= '0;
      chunk_rem <= '0;
      data_rem <= '0;
      chunk_crc <= '0;
      file_crc <= '1;
      check_word <= '0;
      prior <= 1'b0;
      end_chunk <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      version <= version_next;
      records_left <= records_left_next;
      skip_left <= skip_left_next;
      field_index <= field_index_next;
      chunk_rem <= chunk_rem_next;
      data_rem <= data_rem_next;
      chunk_crc <= chunk_crc_next;
      file_crc <= file_crc_next;
      check_word <= check_word_next;
      prior <= prior_next;
      end_chunk <= end_chunk_next;
      res_valid <= rv;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [4:0]  fi;
    logic [31:0] magic, ofs, f1, rate;
    logic [15:0] vers, n, cid, csize, tlen;
    logic        comp, alt;
    logic [31:0] ccrc;

    b = in_word.byte_value;
    phase_next = phase;
    version_next = version;
    records_left_next = records_left;
    skip_left_next = skip_left;
    field_index_next = field_index;
    hb_next = hb;
    chunk_rem_next = chunk_rem;
    data_rem_next = data_rem;
    chunk_crc_next = chunk_crc;
    file_crc_next = file_crc;
    check_word_next = check_word;
    prior_next = prior;
    end_chunk_next = end_chunk;
    rv = 1'b0;
    rw = '0;
    fi = '0;
    magic = '0; ofs = '0; f1 = '0; rate = '0;
    vers = '0; n = '0; cid = '0; csize = '0; tlen = '0;
    comp = 1'b0; alt = 1'b0; ccrc = '0;

    if (take) begin
      if (in_word.start_of_file) begin
        phase_next = sisp_pkg::PH_HDR;
        version_next = '0;
        records_left_next = '0;
        skip_left_next = '0;
        field_index_next = '0;
        chunk_rem_next = '0;
        data_rem_next = '0;
        chunk_crc_next = '0;
        file_crc_next = '1;
        check_word_next = '0;
        prior_next = 1'b0;
        end_chunk_next = 1'b0;
      end
      if (phase_next == sisp_pkg::PH_DONEP) begin
        phase_next = sisp_pkg::PH_DONE;
        rv = 1'b1;
        rw.kind = sisp_pkg::KindDone;
      end else if (phase_next != sisp_pkg::PH_DONE && phase_next != sisp_pkg::PH_ERR) begin
        if (phase_next != sisp_pkg::PH_FCRC) begin
          file_crc_next = sisp_pkg::crc_byte(file_crc_next, b);
        end
        ccrc = sisp_pkg::crc_byte(chunk_crc_next, b);
        fi = field_index_next + 5'd1;
        unique case (phase_next) inside
          sisp_pkg::PH_HDR: begin
            hb_next[field_index_next[3:0]] = b;
            field_index_next = fi;
            if (fi == 5'd16) begin
              magic = {hb_next[0], hb_next[1], hb_next[2], hb_next[3]};
              vers = {hb_next[4], hb_next[5]};
              ofs = {hb_next[12], hb_next[13], hb_next[14], hb_next[15]};
              if (magic != expected_magic) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrMagic; phase_next = sisp_pkg::PH_ERR;
              end else if (vers > 16'd2) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrVersion; phase_next = sisp_pkg::PH_ERR;
              end else if (ofs < 32'd16) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrOffset; phase_next = sisp_pkg::PH_ERR;
              end else begin
                version_next = vers[1:0];
                records_left_next = {hb_next[8], hb_next[9], hb_next[10], hb_next[11]};
                skip_left_next = ofs - 32'd16;
                field_index_next = '0;
                if (skip_left_next != '0) begin
                  phase_next = sisp_pkg::PH_SKIP;
                end else if (vers[1:0] != 2'd2) begin
                  if (records_left_next == '0) begin
                    phase_next = sisp_pkg::PH_DONE; rv = 1'b1; rw.kind = sisp_pkg::KindDone;
                  end else begin
                    phase_next = sisp_pkg::PH_REC;
                  end
                end else begin
                  phase_next = sisp_pkg::PH_CKH; chunk_crc_next = '0;
                end
              end
            end
          end
          sisp_pkg::PH_SKIP: begin
            skip_left_next = skip_left_next - 32'd1;
            if (skip_left_next == '0) begin
              field_index_next = '0;
              if (version_next != 2'd2) begin
                if (records_left_next == '0) begin
                  phase_next = sisp_pkg::PH_DONE; rv = 1'b1; rw.kind = sisp_pkg::KindDone;
                end else begin
                  phase_next = sisp_pkg::PH_REC;
                end
              end else begin
                phase_next = sisp_pkg::PH_CKH; chunk_crc_next = '0;
              end
            end
          end
          sisp_pkg::PH_REC: begin
            hb_next[field_index_next[3:0]] = b;
            field_index_next = fi;
            if (fi == ((version_next == 2'd0) ? 5'd12 : 5'd16)) begin
              n = {hb_next[6], hb_next[7]};
              f1 = {hb_next[12], hb_next[13], hb_next[14], hb_next[15]};
              rate = {hb_next[8], hb_next[9], hb_next[10], hb_next[11]};
              if (version_next == 2'd0) begin
                comp = hb_next[5][7];
                rv = 1'b1;
                rw.phys_cylinder = hb_next[0]; rw.phys_head = hb_next[1];
                rw.id_cylinder = hb_next[2]; rw.id_head = hb_next[3];
                rw.id_sector = hb_next[4]; rw.sector_length = n;
                rw.encoding_code = hb_next[5][0] ? 8'd1 : (hb_next[5][1] ? 8'd2 : 8'd0);
                rw.bit_rate = rate;
                rw.sector_flags = {comp, 1'b0, hb_next[5][4:2]};
              end else if (hb_next[0] != sisp_pkg::RecMarker) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrMarker; phase_next = sisp_pkg::PH_ERR;
              end else if (f1[0] && !prior_next) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrOrphanAlt; phase_next = sisp_pkg::PH_ERR;
              end else begin
                comp = f1[7];
                rv = 1'b1;
                rw.phys_cylinder = hb_next[1]; rw.phys_head = hb_next[2];
                rw.id_cylinder = hb_next[3]; rw.id_head = hb_next[4];
                rw.id_sector = hb_next[5]; rw.sector_length = n;
                rw.encoding_code = hb_next[8];
                rw.bit_rate = {8'h00, rate[23:0]};
                rw.sector_flags = {comp, f1[0], f1[4:2]};
              end
              if (phase_next != sisp_pkg::PH_ERR) begin
                prior_next = 1'b1;
                data_rem_next = comp ? 16'd1 : n;
                phase_next = sisp_pkg::PH_RDATA;
                if (data_rem_next == '0) begin
                  records_left_next = records_left_next - 32'd1;
                  field_index_next = '0;
                  phase_next = (records_left_next == '0) ? sisp_pkg::PH_DONEP
                                                         : sisp_pkg::PH_REC;
                end
              end
            end
          end
          sisp_pkg::PH_RDATA: begin
            rv = 1'b1; rw.kind = sisp_pkg::KindData; rw.payload_byte = b;
            data_rem_next = data_rem_next - 16'd1;
            if (data_rem_next == '0) begin
              records_left_next = records_left_next - 32'd1;
              field_index_next = '0;
              phase_next = (records_left_next == '0) ? sisp_pkg::PH_DONEP
                                                     : sisp_pkg::PH_REC;
            end
          end
          sisp_pkg::PH_CKH: begin
            chunk_crc_next = ccrc;
            hb_next[field_index_next[3:0]] = b;
            field_index_next = fi;
            if (fi == 5'd4) begin
              cid = {hb_next[0], hb_next[1]};
              csize = {hb_next[2], hb_next[3]};
              end_chunk_next = 1'b0;
              tlen = ({16'h0, csize} < 32'(TAG_LIMIT)) ? csize : 16'(TAG_LIMIT);
              if (cid == sisp_pkg::IdSector) begin
                if (csize < 16'd12) begin
                  rv = 1'b1; rw.kind = sisp_pkg::KindError;
                  rw.error_code = sisp_pkg::ErrShort; phase_next = sisp_pkg::PH_ERR;
                end else begin
                  chunk_rem_next = csize - 16'd12;
                  field_index_next = '0;
                  phase_next = sisp_pkg::PH_SCH;
                end
              end else if (cid == sisp_pkg::IdTag) begin
                if (!prior_next) begin
                  rv = 1'b1; rw.kind = sisp_pkg::KindError;
                  rw.error_code = sisp_pkg::ErrOrphanTag; phase_next = sisp_pkg::PH_ERR;
                end else begin
                  data_rem_next = tlen;
                  chunk_rem_next = csize - tlen;
                  if (tlen != '0) begin
                    phase_next = sisp_pkg::PH_TAG;
                  end else begin
                    field_index_next = '0; check_word_next = '0;
                    phase_next = (chunk_rem_next != '0) ? sisp_pkg::PH_CSKIP
                                                        : sisp_pkg::PH_CCRC;
                  end
                end
              end else if (cid == sisp_pkg::IdComment) begin
                data_rem_next = csize;
                chunk_rem_next = '0;
                if (csize != '0) begin
                  phase_next = sisp_pkg::PH_CMT;
                end else begin
                  field_index_next = '0; check_word_next = '0;
                  phase_next = sisp_pkg::PH_CCRC;
                end
              end else begin
                end_chunk_next = (cid == sisp_pkg::IdEnd);
                chunk_rem_next = csize;
                field_index_next = '0; check_word_next = '0;
                phase_next = (csize != '0) ? sisp_pkg::PH_CSKIP : sisp_pkg::PH_CCRC;
              end
            end
          end
          sisp_pkg::PH_SCH: begin
            chunk_crc_next = ccrc;
            hb_next[field_index_next[3:0]] = b;
            field_index_next = fi;
            if (fi == 5'd12) begin
              alt = hb_next[0][6];
              comp = hb_next[0][7];
              n = {hb_next[6], hb_next[7]};
              rate = {hb_next[8], hb_next[9], hb_next[10], hb_next[11]};
              if (alt && !prior_next) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrOrphanAlt; phase_next = sisp_pkg::PH_ERR;
              end else if (comp ? (chunk_rem_next == '0) : (chunk_rem_next < n)) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrShort; phase_next = sisp_pkg::PH_ERR;
              end else begin
                rv = 1'b1;
                prior_next = 1'b1;
                rw.phys_cylinder = hb_next[1]; rw.phys_head = hb_next[2];
                rw.id_cylinder = hb_next[3]; rw.id_head = hb_next[4];
                rw.id_sector = hb_next[5]; rw.sector_length = n;
                rw.encoding_code = hb_next[8];
                rw.bit_rate = {8'h00, rate[23:0]};
                rw.sector_flags = {comp, alt, hb_next[0][2:0]};
                data_rem_next = comp ? 16'd1 : n;
                chunk_rem_next = chunk_rem_next - data_rem_next;
                if (data_rem_next != '0) begin
                  phase_next = sisp_pkg::PH_SDATA;
                end else begin
                  field_index_next = '0; check_word_next = '0;
                  phase_next = (chunk_rem_next != '0) ? sisp_pkg::PH_CSKIP
                                                      : sisp_pkg::PH_CCRC;
                end
              end
            end
          end
          sisp_pkg::PH_SDATA, sisp_pkg::PH_TAG, sisp_pkg::PH_CMT: begin
            chunk_crc_next = ccrc;
            rv = 1'b1;
            rw.kind = (phase_next == sisp_pkg::PH_SDATA) ? sisp_pkg::KindData :
                      ((phase_next == sisp_pkg::PH_TAG) ? sisp_pkg::KindTag
                                                        : sisp_pkg::KindComment);
            rw.payload_byte = b;
            data_rem_next = data_rem_next - 16'd1;
            if (data_rem_next == '0) begin
              field_index_next = '0; check_word_next = '0;
              phase_next = (chunk_rem_next != '0) ? sisp_pkg::PH_CSKIP
                                                  : sisp_pkg::PH_CCRC;
            end
          end
          sisp_pkg::PH_CSKIP: begin
            chunk_crc_next = ccrc;
            chunk_rem_next = chunk_rem_next - 16'd1;
            if (chunk_rem_next == '0) begin
              field_index_next = '0; check_word_next = '0;
              phase_next = sisp_pkg::PH_CCRC;
            end
          end
          sisp_pkg::PH_CCRC: begin
            check_word_next = {check_word_next[23:0], b};
            field_index_next = fi;
            if (fi == 5'd4) begin
              if (check_word_next != chunk_crc_next) begin
                rv = 1'b1; rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrChunkCrc; phase_next = sisp_pkg::PH_ERR;
              end else begin
                field_index_next = '0; check_word_next = '0;
                if (end_chunk_next) begin
                  phase_next = sisp_pkg::PH_FCRC;
                end else begin
                  phase_next = sisp_pkg::PH_CKH; chunk_crc_next = '0;
                end
              end
            end
          end
          sisp_pkg::PH_FCRC: begin
            check_word_next = {check_word_next[23:0], b};
            field_index_next = fi;
            if (fi == 5'd4) begin
              rv = 1'b1;
              if (check_word_next != file_crc_next) begin
                rw.kind = sisp_pkg::KindError;
                rw.error_code = sisp_pkg::ErrFileCrc; phase_next = sisp_pkg::PH_ERR;
              end else begin
                rw.kind = sisp_pkg::KindDone; phase_next = sisp_pkg::PH_DONE;
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sector_image_stream_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sector image stream parser
// Parses a floppy sector image one byte per word into sector headers,
// data, tag and comment bytes, done and error words.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle while in_stall is low and gives
// at most one result word per byte; the word is registered in the core and
// then written into the queue before it reaches the output. The parser core
// handles each byte combinationally ahead of its register: field capture,
// phase decisions and the bytewise CRC-32 updates for the chunk and file
// checks all happen there. Results go into a small queue, so a stalled
// output does not stop input until the queue is nearly full; the input stall
// rises when only one free entry is left, which keeps room for the word
// still in the core. A word with start_of_file set restarts the parser
// before its byte is used. After an error or done, bytes are dropped until
// the next start of file. The magic register may be written whenever the
// block is idle; its write port is always ready.
// ----------------------------------------------------------------------------
module sector_image_stream_parser #(
  parameter int TAG_LIMIT = sisp_pkg::TagLimitDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sisp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output sisp_pkg::out_word_t out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [31:0]         cfg_data
);
  logic [31:0] expected_magic;
  logic        take;
  logic        res_valid;
  logic        almost_full;
  sisp_pkg::out_word_t res_word;

  assign cfg_ready = 1'b1;
  assign in_stall = almost_full;
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= '0;
    end else if (cfg_valid) begin
      expected_magic <= cfg_data;
    end
  end

  sisp_core #(.TAG_LIMIT(TAG_LIMIT)) u_core (
    .clk(clk), .rst(rst), .expected_magic(expected_magic),
    .take(take), .in_word(in_data),
    .res_valid(res_valid), .res_word(res_word)
  );

  sisp_queue #(.DEPTH(sisp_pkg::QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push(res_valid), .push_word(res_word),
    .almost_full(almost_full), .valid(out_valid), .stall(out_stall),
    .word(out_data)
  );
endmodule
`default_nettype wire
